// File: rtl/slir_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slir_pkg: shared types and constants for the sorted list insert/remove block
// Holds the field widths, the operation codes and the flag bundle that each
// list cell passes to its neighbors and to the top level.
// ----------------------------------------------------------------------------
package slir_pkg;

  // Field widths of the input and result transfers.
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;
  localparam int POS_W   = 4;

  // Operation codes carried on the kind field.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Comparison flags of one cell against the value of the current transfer.
  typedef struct packed {
    logic le;  // holds a valid entry that is less than or equal to the value
    logic lt;  // holds a valid entry that is strictly less than the value
    logic eq;  // holds a valid entry equal to the value
  } cell_flags_t;

endpackage : slir_pkg
`default_nettype wire

// File: rtl/slir_encode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slir_encode: one-hot to binary index encoder
// Turns the single hit flag raised by one list cell into that cell's index.
// ----------------------------------------------------------------------------
module slir_encode #(
  parameter int N     = 16,
  parameter int IDX_W = 4
) (
  input  wire logic [N-1:0]     hot,
  output logic      [IDX_W-1:0] idx
);

  // OR together the indexes of all raised flags; at most one is raised.
  always_comb begin
    idx = '0;
    for (int i = 0; i < N; i++) begin
      if (hot[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
  end

endmodule : slir_encode
`default_nettype wire

// File: rtl/slir_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slir_cell: one storage cell of the sorted list
// Holds one entry, compares it with the broadcast value and, on an update,
// takes its next entry from itself, the value, or a neighbor cell.
// ----------------------------------------------------------------------------
module slir_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire logic                              clk,
  input  wire logic                              upd,
  input  wire logic                              kind,
  input  wire logic signed [slir_pkg::VALUE_W-1:0] value,
  input  wire logic [CNT_W-1:0]                  count,
  input  wire logic                              found,
  input  wire slir_pkg::cell_flags_t             left_flags,
  input  wire logic signed [slir_pkg::VALUE_W-1:0] left_entry,
  input  wire logic signed [slir_pkg::VALUE_W-1:0] right_entry,
  output slir_pkg::cell_flags_t                  flags,
  output logic signed [slir_pkg::VALUE_W-1:0]    entry,
  output logic                                   hit
);
  import slir_pkg::*;

  logic                      valid;
  logic signed [VALUE_W-1:0] entry_r;
  logic signed [VALUE_W-1:0] entry_nxt;

  // The cell holds a live entry when its index is below the fill count.
  assign valid = (count > CNT_W'(IDX));

  // Compare the stored entry with the broadcast value.
  always_comb begin
    flags.le = valid && (entry_r <= value);
    flags.lt = valid && (entry_r < value);
    flags.eq = valid && (entry_r == value);
  end

  // Insert lands where the left neighbor is still at or below the value and
  // this cell is not; remove hits the first cell of a run of equal entries.
  always_comb begin
    if (kind == OP_INSERT) begin
      hit = left_flags.le && !flags.le;
    end else begin
      hit = flags.eq && !left_flags.eq;
    end
  end

  // Next entry: keep, take the value, shift up from the left or down from
  // the right.
  always_comb begin
    entry_nxt = entry_r;
    if (kind == OP_INSERT) begin
      if (!flags.le) begin
        entry_nxt = left_flags.le ? value : left_entry;
      end
    end else begin
      if (found && !flags.lt) begin
        entry_nxt = right_entry;
      end
    end
  end

  // Entry register, written only when the operation takes effect.
  always_ff @(posedge clk) begin
    if (upd) begin
      entry_r <= entry_nxt;
    end
  end

  assign entry = entry_r;

endmodule : slir_cell
`default_nettype wire

// File: rtl/sorted_list_insert_remove_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_top: sorted list with insert and remove
// Keeps up to LIST_DEPTH signed values in ascending order in a row of cells.
//
// Input channel (in_valid, in_stall, in_kind, in_value): each transfer is an
// insert (kind 0) or a remove of the first equal entry (kind 1). An insert
// goes after any equal entries and fails on a full list; a remove fails when
// the value is absent.
// Result channel (out_valid, out_stall, out_ok, out_count, out_position):
// one result per input transfer, in order; position is zero on failure.
// The result is registered at the edge that takes the input. Throughput is
// one item per cycle while the receiver does not stall; every cell compares
// against the broadcast value and shifts with its neighbors in that same
// cycle, so the list update is finished before the next item arrives.
// Reset empties the list and drops any pending result. While the receiver
// stalls a pending result, the result register holds its contents and in_stall is raised.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_top #(
  parameter int LIST_DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_kind,
  input  wire logic signed [slir_pkg::VALUE_W-1:0] in_value,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_ok,
  output logic [slir_pkg::COUNT_W-1:0]          out_count,
  output logic [slir_pkg::POS_W-1:0]            out_position
);
  import slir_pkg::*;

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  logic                      accept;
  logic                      full;
  logic                      found;
  logic                      ok;
  logic                      upd;
  logic [IDX_W-1:0]          pos;
  logic [LIST_DEPTH-1:0]     hits;
  logic [LIST_DEPTH-1:0]     eqs;
  cell_flags_t               flags    [LIST_DEPTH];
  cell_flags_t               lflags   [LIST_DEPTH];
  logic signed [VALUE_W-1:0] entries  [LIST_DEPTH];
  logic signed [VALUE_W-1:0] lentries [LIST_DEPTH];
  logic signed [VALUE_W-1:0] rentries [LIST_DEPTH];

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_ok_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [POS_W-1:0]   out_position_r;

  // Input transfer is taken whenever the result register is free or drains.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // Neighbor wiring of the cell row; the row ends behave as open boundaries.
  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign lflags[g]   = '{le: 1'b1, lt: 1'b1, eq: 1'b0};
      assign lentries[g] = in_value;
    end else begin : g_mid
      assign lflags[g]   = flags[g-1];
      assign lentries[g] = entries[g-1];
    end
    if (g == LIST_DEPTH - 1) begin : g_last
      assign rentries[g] = entries[g];
    end else begin : g_inner
      assign rentries[g] = entries[g+1];
    end
    assign eqs[g] = flags[g].eq;

    slir_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .upd         (upd),
      .kind        (in_kind),
      .value       (in_value),
      .count       (count_r),
      .found       (found),
      .left_flags  (lflags[g]),
      .left_entry  (lentries[g]),
      .right_entry (rentries[g]),
      .flags       (flags[g]),
      .entry       (entries[g]),
      .hit         (hits[g])
    );
  end

  // Index of the cell that the operation touches.
  slir_encode #(
    .N     (LIST_DEPTH),
    .IDX_W (IDX_W)
  ) u_encode (
    .hot (hits),
    .idx (pos)
  );

  // Outcome of the current operation.
  assign full  = (count_r == CNT_W'(LIST_DEPTH));
  assign found = |eqs;
  assign ok    = (in_kind == OP_INSERT) ? !full : found;
  assign upd   = accept && ok;

  // Fill count follows every successful operation.
  always_comb begin
    count_nxt = count_r;
    if (upd) begin
      if (in_kind == OP_INSERT) begin
        count_nxt = count_r + CNT_W'(1);
      end else begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  // Result register valid flag.
  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded on each accepted transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_ok_r       <= ok;
      out_count_r    <= COUNT_W'(count_nxt);
      out_position_r <= ok ? POS_W'(pos) : '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_ok       = out_ok_r;
  assign out_count    = out_count_r;
  assign out_position = out_position_r;

endmodule : sorted_list_insert_remove_top
`default_nettype wire

// File: test/sorted_list_checker.sv
// ----------------------------------------------------------------------------
// sorted_list_checker: result predictor and comparator for the sorted list
// Watches both channels of the block. Every accepted input transfer is applied
// to a private copy of the ascending list, and the expected result goes into
// an in-order store. Every accepted result transfer is compared field by field
// with the oldest expectation.
// ----------------------------------------------------------------------------
module sorted_list_checker #(
  parameter int LIST_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic                               in_kind,
  input  logic signed [slir_pkg::VALUE_W-1:0] in_value,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic                               out_ok,
  input  logic [slir_pkg::COUNT_W-1:0]       out_count,
  input  logic [slir_pkg::POS_W-1:0]         out_position,
  output int                                 mismatch_count,
  output int                                 pending,
  output int                                 result_count,
  output int                                 success_count,
  output int                                 full_reject_count
);
  import slir_pkg::*;

  typedef struct packed {
    logic               ok;
    logic [COUNT_W-1:0] count;
    logic [POS_W-1:0]   position;
  } list_result_t;

  // Private copy of the list contents and its fill level.
  logic signed [VALUE_W-1:0] sorted_vals [LIST_DEPTH];
  int                        fill;
  list_result_t              expected_results [$];

  // Apply one operation to the private list and return the expected result.
  function automatic list_result_t apply_op(input logic kind,
                                            input logic signed [VALUE_W-1:0] v);
    list_result_t r;
    int           pos;
    r = '0;
    pos = 0;
    if (kind == OP_INSERT) begin
      if (fill >= LIST_DEPTH) begin
        r.count = COUNT_W'(fill);
      end else begin
        // The new value goes after every entry that is less or equal.
        while (pos < fill && v >= sorted_vals[pos]) pos++;
        for (int i = fill; i > pos; i--) sorted_vals[i] = sorted_vals[i-1];
        sorted_vals[pos] = v;
        fill++;
        r.ok = 1'b1;
        r.count = COUNT_W'(fill);
        r.position = POS_W'(pos);
      end
    end else begin
      // Removal takes the lowest-indexed equal entry.
      while (pos < fill && sorted_vals[pos] != v) pos++;
      if (pos == fill) begin
        r.count = COUNT_W'(fill);
      end else begin
        for (int i = pos; i + 1 < fill; i++) sorted_vals[i] = sorted_vals[i+1];
        fill--;
        r.ok = 1'b1;
        r.count = COUNT_W'(fill);
        r.position = POS_W'(pos);
      end
    end
    return r;
  endfunction

  // Compare finished results first, then predict for the new input transfer.
  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      fill = 0;
      expected_results.delete();
      mismatch_count = 0;
      result_count = 0;
      success_count = 0;
      full_reject_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        result_count++;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result transfer with nothing expected (ok=%0b count=%0d pos=%0d)",
                   $time, out_ok, out_count, out_position);
        end else begin
          want = expected_results.pop_front();
          if (out_ok !== want.ok) begin
            mismatch_count++;
            $display("%0t: ok mismatch, expected %0b, got %0b", $time, want.ok, out_ok);
          end
          if (out_count !== want.count) begin
            mismatch_count++;
            $display("%0t: count mismatch, expected %0d, got %0d",
                     $time, want.count, out_count);
          end
          if (out_position !== want.position) begin
            mismatch_count++;
            $display("%0t: position mismatch, expected %0d, got %0d",
                     $time, want.position, out_position);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_kind == OP_INSERT && fill >= LIST_DEPTH) full_reject_count++;
        want = apply_op(in_kind, in_value);
        if (want.ok) success_count++;
        expected_results.push_back(want);
      end
    end
    pending = expected_results.size();
  end

endmodule : sorted_list_checker

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for the sorted list insert/remove block
// Drives a directed sequence through the list's corner cases, then random
// insert and remove traffic with shifting insert/remove balance and a small
// pool of repeated values, under several idle and stall mixes and one long
// receiver hold. The checker beside the block does all prediction.
// ----------------------------------------------------------------------------
module tb;
  import slir_pkg::*;

  localparam int LIST_DEPTH   = 16;
  localparam int RANDOM_ITEMS = 1330;
  localparam int PHASE_ITEMS  = RANDOM_ITEMS / 4;
  localparam int HOLD_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_kind;
  logic signed [VALUE_W-1:0]  in_value;
  logic                       out_valid;
  logic                       out_stall;
  logic                       out_ok;
  logic [COUNT_W-1:0]         out_count;
  logic [POS_W-1:0]           out_position;

  int mismatch_count;
  int pending;
  int result_count;
  int success_count;
  int full_reject_count;

  int send_idle_pct;
  int stall_pct;
  logic hold_req;
  logic hold_done;
  int cycle_count;
  int insert_count;
  int remove_count;

  logic signed [VALUE_W-1:0] value_pool [8];

  sorted_list_insert_remove_top #(.LIST_DEPTH(LIST_DEPTH)) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_ok       (out_ok),
    .out_count    (out_count),
    .out_position (out_position)
  );

  sorted_list_checker #(.LIST_DEPTH(LIST_DEPTH)) i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ok            (out_ok),
    .out_count         (out_count),
    .out_position      (out_position),
    .mismatch_count    (mismatch_count),
    .pending           (pending),
    .result_count      (result_count),
    .success_count     (success_count),
    .full_reject_count (full_reject_count)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit in case the block stops responding.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold when requested.
  initial begin
    out_stall <= 1'b0;
    hold_done <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done <= 1'b1;
        out_stall <= 1'b0;
      end else begin
        out_stall <= (rst_n && $urandom_range(99) < stall_pct);
      end
    end
  end

  // Offer one transfer, idling first at random, and wait until it is taken.
  // The stall is sampled mid-cycle, where it is settled for the coming edge.
  task automatic offer(input logic kind, input logic signed [VALUE_W-1:0] v);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_value <= v;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    if (kind == OP_INSERT) insert_count++;
    else remove_count++;
  endtask

  // Pick a value: mostly repeats from a pool so removes find their targets.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 55) return value_pool[$urandom_range(7)];
    if (r < 75) return $signed($urandom_range(8)) - 4;
    if (r < 85) begin
      case ($urandom_range(3))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return 0;
        default: return -1;
      endcase
    end
    return $signed($urandom);
  endfunction

  // Random traffic whose insert share swings so the list fills and drains.
  task automatic random_phase(input int n_items, input int idle_pct, input int stl_pct);
    int insert_pct;
    int run_left;
    send_idle_pct = idle_pct;
    stall_pct     = stl_pct;
    insert_pct    = 80;
    run_left      = $urandom_range(60, 20);
    for (int i = 0; i < n_items; i++) begin
      if (run_left == 0) begin
        insert_pct = (insert_pct > 50) ? 25 : 80;
        run_left   = $urandom_range(60, 20);
        value_pool[$urandom_range(7)] = $signed($urandom);
      end
      run_left--;
      offer(($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE, pick_value());
    end
  endtask

  // Main sequence: reset, directed cases, random phases, drain and verdict.
  initial begin
    in_valid <= 1'b0;
    in_kind  <= OP_INSERT;
    in_value <= '0;
    rst_n    <= 1'b0;
    hold_req <= 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    insert_count  = 0;
    remove_count  = 0;
    foreach (value_pool[k]) value_pool[k] = $signed($urandom);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: remove on an empty list, extremes, duplicates, absent value.
    offer(OP_REMOVE, 7);
    offer(OP_INSERT, VAL_MAX);
    offer(OP_INSERT, VAL_MIN);
    offer(OP_INSERT, 0);
    offer(OP_INSERT, -1);
    offer(OP_INSERT, 0);
    offer(OP_REMOVE, 0);
    offer(OP_REMOVE, 5);
    // Fill to capacity with a mix of duplicates, then insert into a full list.
    for (int k = 0; k < 12; k++) offer(OP_INSERT, (k % 3 == 0) ? 0 : k * 1000 - 5000);
    offer(OP_INSERT, 3);
    offer(OP_REMOVE, VAL_MAX);
    offer(OP_REMOVE, VAL_MIN);

    // Random phases; the first also carries the long receiver hold.
    hold_req <= 1'b1;
    random_phase(PHASE_ITEMS, 0, 0);
    random_phase(PHASE_ITEMS, 54, 0);
    random_phase(PHASE_ITEMS, 0, 54);
    random_phase(RANDOM_ITEMS - 3 * PHASE_ITEMS, 11, 11);

    // Drain outstanding results, then let the block settle before the verdict.
    in_valid <= 1'b0;
    stall_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("Sent %0d transfers (%0d inserts, %0d removes) over four idle/stall mixes",
             insert_count + remove_count, insert_count, remove_count);
    $display("and one %0d-cycle receiver hold; %0d results, %0d took effect, %0d full rejects.",
             HOLD_CYCLES, result_count, success_count, full_reject_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule : tb
